>>> rtl/touch_packet_decoder_scaler_macros.svh
// Assertion helpers shared by the queue and scaler modules.
`ifndef TOUCH_PACKET_DECODER_SCALER_MACROS_SVH
`define TOUCH_PACKET_DECODER_SCALER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TPDS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define TPDS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> rtl/tpds_pkg.sv
package tpds_pkg;

  // Serial frame format
  localparam logic [7:0] SYNC_BYTE   = 8'h55;  // 'U'
  localparam logic [7:0] TOUCH_TYPE  = 8'h54;  // 'T'
  localparam int         FRAME_LEN   = 10;
  localparam int         PAYLOAD_LEN = 8;
  localparam int         FRAME_IDX_W = $clog2(FRAME_LEN);
  localparam int         PAYLOAD_IDX_W = $clog2(PAYLOAD_LEN);

  // Field widths
  localparam int RAW_W     = 16;
  localparam int WIN_W     = 13;
  localparam int OUT_W     = 13;
  localparam int MODE_W    = 4;
  localparam int ORIGIN_W  = 24;
  localparam int PROD_W    = RAW_W + WIN_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int FIX_W     = PROD_W + 3;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Mode bit positions
  localparam int MODE_INITIAL_ONLY = 0;
  localparam int MODE_MIRROR_X     = 1;
  localparam int MODE_MIRROR_Y     = 2;
  localparam int MODE_SUPPRESS     = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ORIGIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_WIN_ORIGIN,
    REG_WIN_WIDTH,
    REG_WIN_HEIGHT,
    REG_CAL_X,
    REG_CAL_Y,
    REG_CAL_WIDTH,
    REG_CAL_HEIGHT
  } tpds_reg_e;

  localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = 13'd720;
  localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 13'd576;
  localparam logic [RAW_W-1:0] CAL_SPAN_RST   = 16'd1000;

  // Coordinate field width inside window_origin
  localparam int COORD_BITS_DEF = 12;

  // Job queue between parser and scaler
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode_bits;
    logic [ORIGIN_W-1:0] window_origin;
    logic [WIN_W-1:0]    window_width;
    logic [WIN_W-1:0]    window_height;
    logic [RAW_W-1:0]    cal_x;
    logic [RAW_W-1:0]    cal_y;
    logic [RAW_W-1:0]    cal_width;
    logic [RAW_W-1:0]    cal_height;
  } tpds_cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] rx;
    logic [RAW_W-1:0] ry;
    logic [RAW_W-1:0] rz;
  } tpds_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpds_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_ADD,
    ST_OUT
  } tpds_state_e;

endpackage

>>> rtl/touch_packet_decoder_scaler.sv
// Touch controller frame decoder with calibration scaling.
//
// Input channel: one serial byte per word on rx_byte_i (in_valid_i / in_stall_o).
// Bytes are framed on a 'U' sync byte; a 10-byte frame with type 'T' becomes one
// touch word. Output channel: x_pos_o, y_pos_o, pressure_o (out_valid_o /
// out_stall_i). Non-touch frames, filtered touches and suppressed results give
// no output word. The user must write configuration registers through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while idle; the block does not enforce it.
//
// Throughput: the parser takes one byte per cycle while the job queue has room.
// The scaler handles one touch at a time (x then y, each a prep, a multiply, 29
// divide steps, a clip and a place step, plus a dequeue and an output step) on
// the shared one-bit-per-cycle restoring divider. A two-entry job queue sits
// between them.
// Stall: a word waits in the output register while out_stall_i is high; bytes
// keep flowing until the job queue fills, then in_stall_o rises.
// Reset: asynchronous, active low; parser waits for sync, queue empties,
// registers return to their defaults (window 720 x 576, cal span 1000 x 1000).
module touch_packet_decoder_scaler #(
  parameter int COORD_BITS = tpds_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  // touch output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tpds_pkg::OUT_W-1:0]        x_pos_o,
  output logic [tpds_pkg::OUT_W-1:0]        y_pos_o,
  output logic [tpds_pkg::RAW_W-1:0]        pressure_o,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [tpds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  tpds_pkg::tpds_cfg_t   cfg_q;
  tpds_pkg::tpds_qstat_t q_stat;
  tpds_pkg::tpds_job_t   job_in, job_out;
  logic                  in_accept;
  logic                  push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_bits     <= '0;
      cfg_q.window_origin <= '0;
      cfg_q.window_width  <= tpds_pkg::WIN_WIDTH_RST;
      cfg_q.window_height <= tpds_pkg::WIN_HEIGHT_RST;
      cfg_q.cal_x         <= '0;
      cfg_q.cal_y         <= '0;
      cfg_q.cal_width     <= tpds_pkg::CAL_SPAN_RST;
      cfg_q.cal_height    <= tpds_pkg::CAL_SPAN_RST;
    end else if (cfg_we_i) begin
      case (tpds_pkg::tpds_reg_e'(cfg_idx_i))
        tpds_pkg::REG_MODE:       cfg_q.mode_bits     <= cfg_wdata_i[tpds_pkg::MODE_W-1:0];
        tpds_pkg::REG_WIN_ORIGIN: cfg_q.window_origin <= cfg_wdata_i[tpds_pkg::ORIGIN_W-1:0];
        tpds_pkg::REG_WIN_WIDTH:  cfg_q.window_width  <= cfg_wdata_i[tpds_pkg::WIN_W-1:0];
        tpds_pkg::REG_WIN_HEIGHT: cfg_q.window_height <= cfg_wdata_i[tpds_pkg::WIN_W-1:0];
        tpds_pkg::REG_CAL_X:      cfg_q.cal_x         <= cfg_wdata_i[tpds_pkg::RAW_W-1:0];
        tpds_pkg::REG_CAL_Y:      cfg_q.cal_y         <= cfg_wdata_i[tpds_pkg::RAW_W-1:0];
        tpds_pkg::REG_CAL_WIDTH:  cfg_q.cal_width     <= cfg_wdata_i[tpds_pkg::RAW_W-1:0];
        tpds_pkg::REG_CAL_HEIGHT: cfg_q.cal_height    <= cfg_wdata_i[tpds_pkg::RAW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold bytes off only when no room is left for a finished touch
  assign in_stall_o = q_stat.full;
  assign in_accept  = in_valid_i && !q_stat.full;

  // Frame parser and touch filter
  tpds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .rx_byte_i   (rx_byte_i),
    .mode_bits_i (cfg_q.mode_bits),
    .push_o      (push),
    .job_o       (job_in)
  );

  // Decoupling queue of raw touches
  tpds_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  // Calibration scaler with output register
  tpds_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_job_i     (job_out),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .pressure_o  (pressure_o)
  );

endmodule

>>> rtl/tpds_queue.sv
`include "touch_packet_decoder_scaler_macros.svh"

module tpds_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tpds_pkg::tpds_job_t   job_i,
  input  logic                  pop_i,
  output tpds_pkg::tpds_job_t   job_o,
  output tpds_pkg::tpds_qstat_t stat_o
);

  localparam int PW = tpds_pkg::QPTR_W;
  localparam int CW = PW + 1;

  tpds_pkg::tpds_job_t mem_q [tpds_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(tpds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(tpds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CW'(tpds_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  `TPDS_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && stat_o.full, "push into full queue")
  `TPDS_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && stat_o.empty, "pop from empty queue")

endmodule

>>> rtl/tpds_front.sv
module tpds_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [7:0]                           rx_byte_i,
  input  logic [tpds_pkg::MODE_W-1:0]          mode_bits_i,
  output logic                                 push_o,
  output tpds_pkg::tpds_job_t                  job_o
);

  localparam int IW = tpds_pkg::FRAME_IDX_W;
  localparam int BW = tpds_pkg::PAYLOAD_IDX_W;

  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    bytes_q [tpds_pkg::PAYLOAD_LEN];
  logic [BW-1:0] wr_idx;
  logic          store;
  logic          keep;

  // Payload byte n of the frame lands at slot n-1
  assign wr_idx = BW'(idx_q - IW'(1));
  assign store  = accept_i && (idx_q != '0) && (idx_q <= IW'(tpds_pkg::PAYLOAD_LEN));

  assign keep = (bytes_q[0] == tpds_pkg::TOUCH_TYPE)
             && !(mode_bits_i[tpds_pkg::MODE_INITIAL_ONLY] && !bytes_q[1][0])
             && !mode_bits_i[tpds_pkg::MODE_SUPPRESS];

  always_comb begin
    idx_d  = idx_q;
    push_o = 1'b0;
    if (accept_i) begin
      if (idx_q == '0) begin
        if (rx_byte_i == tpds_pkg::SYNC_BYTE) begin
          idx_d = IW'(1);
        end
      end else if (idx_q == IW'(tpds_pkg::FRAME_LEN - 1)) begin
        // checksum byte closes the frame
        idx_d  = '0;
        push_o = keep;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[wr_idx] <= rx_byte_i;
    end
  end

  assign job_o.rx = {bytes_q[3], bytes_q[2]};
  assign job_o.ry = {bytes_q[5], bytes_q[4]};
  assign job_o.rz = {bytes_q[7], bytes_q[6]};

endmodule

>>> rtl/tpds_back.sv
`include "touch_packet_decoder_scaler_macros.svh"

module tpds_back #(
  parameter int COORD_BITS = tpds_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tpds_pkg::tpds_cfg_t           cfg_i,
  input  tpds_pkg::tpds_qstat_t         q_stat_i,
  input  tpds_pkg::tpds_job_t           q_job_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tpds_pkg::OUT_W-1:0]    x_pos_o,
  output logic [tpds_pkg::OUT_W-1:0]    y_pos_o,
  output logic [tpds_pkg::RAW_W-1:0]    pressure_o
);

  localparam int RW    = tpds_pkg::RAW_W;
  localparam int WW    = tpds_pkg::WIN_W;
  localparam int OW    = tpds_pkg::OUT_W;
  localparam int PW    = tpds_pkg::PROD_W;
  localparam int FW    = tpds_pkg::FIX_W;
  localparam int CW    = tpds_pkg::DIV_CNT_W;
  localparam int EXT_W = (2 * COORD_BITS > tpds_pkg::ORIGIN_W) ?
                         2 * COORD_BITS : tpds_pkg::ORIGIN_W;
  localparam int SUM_W = ((COORD_BITS > OW) ? COORD_BITS : OW) + 1;

  tpds_pkg::tpds_state_e state_q, state_d;
  logic                  axis_q, axis_d;  // 0: x, 1: y
  logic [CW-1:0]         cnt_q, cnt_d;

  tpds_pkg::tpds_job_t   job_q, job_d;
  logic                  neg_q, neg_d;
  logic [RW-1:0]         mag_q, mag_d;
  logic [WW-1:0]         size_q, size_d;
  logic [RW-1:0]         span_q, span_d;
  logic [PW-1:0]         quo_q, quo_d;   // product, then quotient
  logic [RW-1:0]         rem_q, rem_d;
  logic [WW-1:0]         tc_q, tc_d;     // coordinate inside the window
  logic [OW-1:0]         x_q, x_d;
  logic [OW-1:0]         y_q, y_d;

  logic [EXT_W-1:0]      org_ext;
  logic [COORD_BITS-1:0] org;
  logic [RW-1:0]         raw, cal_org, cal_span;
  logic [WW-1:0]         win_size;
  logic                  mirror;
  logic [RW:0]           shifted;
  logic signed [FW-1:0]  sv, t, size_s;
  logic [SUM_W-1:0]      sum;
  logic [OW-1:0]         placed;

  assign org_ext  = EXT_W'(cfg_i.window_origin);
  assign org      = axis_q ? org_ext[2*COORD_BITS-1:COORD_BITS] : org_ext[COORD_BITS-1:0];
  assign raw      = axis_q ? job_q.ry : job_q.rx;
  assign cal_org  = axis_q ? cfg_i.cal_y : cfg_i.cal_x;
  assign cal_span = axis_q ? cfg_i.cal_height : cfg_i.cal_width;
  assign win_size = axis_q ? cfg_i.window_height : cfg_i.window_width;
  assign mirror   = axis_q ? cfg_i.mode_bits[tpds_pkg::MODE_MIRROR_Y]
                           : cfg_i.mode_bits[tpds_pkg::MODE_MIRROR_X];

  // restoring divide step
  assign shifted = {rem_q, quo_q[PW-1]};

  // sign, mirror
  assign size_s = signed'(FW'(size_q));
  assign sv     = neg_q ? -signed'(FW'(quo_q)) : signed'(FW'(quo_q));
  assign t      = mirror ? (size_s - signed'(FW'(1)) - sv) : sv;

  // place into the window and saturate to the output range
  assign sum    = SUM_W'(org) + SUM_W'(tc_q);
  assign placed = (sum > SUM_W'(tpds_pkg::OUT_MAX)) ? tpds_pkg::OUT_MAX : sum[OW-1:0];

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    job_d       = job_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    size_d      = size_q;
    span_d      = span_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    tc_d        = tc_q;
    x_d         = x_q;
    y_d         = y_q;
    q_pop_o     = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      tpds_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          axis_d  = 1'b0;
          state_d = tpds_pkg::ST_PREP;
        end
      end
      tpds_pkg::ST_PREP: begin
        neg_d   = raw < cal_org;
        mag_d   = (raw < cal_org) ? cal_org - raw : raw - cal_org;
        size_d  = (win_size == '0) ? WW'(1) : win_size;
        span_d  = (cal_span == '0) ? RW'(1) : cal_span;
        state_d = tpds_pkg::ST_MUL;
      end
      tpds_pkg::ST_MUL: begin
        quo_d   = PW'(mag_q) * PW'(size_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = tpds_pkg::ST_DIV;
      end
      tpds_pkg::ST_DIV: begin
        if (shifted >= {1'b0, span_q}) begin
          rem_d = RW'(shifted - {1'b0, span_q});
          quo_d = {quo_q[PW-2:0], 1'b1};
        end else begin
          rem_d = shifted[RW-1:0];
          quo_d = {quo_q[PW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PW - 1)) begin
          state_d = tpds_pkg::ST_FIX;
        end
      end
      tpds_pkg::ST_FIX: begin
        if (t[FW-1]) begin
          tc_d = '0;
        end else if (t >= size_s) begin
          tc_d = size_q - WW'(1);
        end else begin
          tc_d = t[WW-1:0];
        end
        state_d = tpds_pkg::ST_ADD;
      end
      tpds_pkg::ST_ADD: begin
        if (axis_q) begin
          y_d     = placed;
          state_d = tpds_pkg::ST_OUT;
        end else begin
          x_d     = placed;
          axis_d  = 1'b1;
          state_d = tpds_pkg::ST_PREP;
        end
      end
      tpds_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = tpds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpds_pkg::ST_IDLE;
      axis_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    size_q <= size_d;
    span_q <= span_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    tc_q   <= tc_d;
    x_q    <= x_d;
    y_q    <= y_d;
  end

  assign x_pos_o    = x_q;
  assign y_pos_o    = y_q;
  assign pressure_o = job_q.rz;

  `TPDS_ASSERT(a_div_cnt, clk_i, rst_ni, (state_q == tpds_pkg::ST_DIV) |-> (cnt_q < CW'(PW)), "divide step count overran")
  `TPDS_ASSERT(a_clip, clk_i, rst_ni, (state_q == tpds_pkg::ST_ADD) |-> (tc_q < size_q), "clipped coordinate outside window")
  `TPDS_ASSERT(a_y_then_out, clk_i, rst_ni, ((state_q == tpds_pkg::ST_ADD) && axis_q) |=> (state_q == tpds_pkg::ST_OUT), "y axis done without presenting word")
  `TPDS_ASSERT(a_out_release, clk_i, rst_ni, ((state_q == tpds_pkg::ST_OUT) && !out_stall_i) |=> (state_q == tpds_pkg::ST_IDLE), "taken word not released")

endmodule
